/* design/arc_midpoint_from_center_offset_defines.svh */
// assertion macros for the arc midpoint block
`ifndef ARC_MIDPOINT_FROM_CENTER_OFFSET_DEFINES_SVH
`define ARC_MIDPOINT_FROM_CENTER_OFFSET_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define AMFCO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define AMFCO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/amfco_pkg.sv */
package amfco_pkg;

  localparam int COORD_BITS = 24;
  localparam int CW  = COORD_BITS;
  localparam int UW  = CW + 2;          // 2*offset - chord
  localparam int SQW = 2 * CW + 2;      // squares
  localparam int RK  = CW + 2;          // root bits
  localparam int RN  = 2 * RK;          // radicand bits
  localparam int NB  = CW + UW;         // dividend / quotient bits
  localparam int DW  = RK;              // divisor bits
  localparam int MW  = NB + 2;          // unclamped midpoint

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_HALF = 2'd1,
    ST_LONG = 2'd2,
    ST_SAT  = 2'd3
  } amfco_status_t;

  localparam logic signed [CW-1:0] MID_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MID_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_z;
    logic signed [CW-1:0] center_off_x;
    logic signed [CW-1:0] center_off_y;
  } amfco_in_t;

  typedef struct packed {
    logic signed [CW-1:0] mid_x;
    logic signed [CW-1:0] mid_y;
    logic signed [CW-1:0] mid_z;
    logic [1:0]           status;
  } amfco_out_t;

  // everything one item carries down the pipe
  typedef struct packed {
    logic signed [CW:0]   cx;
    logic signed [CW:0]   cy;
    logic signed [CW-1:0] hx;
    logic signed [CW-1:0] hy;
    logic signed [CW-1:0] z;
    logic                 ux_neg;
    logic                 uy_neg;
    logic [UW-1:0]        ux_m;
    logic [UW-1:0]        uy_m;
    logic [CW-1:0]        ox_m;
    logic [CW-1:0]        oy_m;
    logic [CW:0]          dx_m;
    logic [CW:0]          dy_m;
    logic                 lt;
    logic                 eq;
    logic [SQW-1:0]       sq_ox;
    logic [SQW-1:0]       sq_oy;
    logic [SQW-1:0]       sq_dx;
    logic [SQW-1:0]       sq_dy;
    logic [RN-1:0]        rem_r;
    logic [RN-1:0]        rem_h;
    logic [RK-1:0]        root_r;
    logic [RK-1:0]        root_h;
    logic [NB-1:0]        num_x;
    logic [NB-1:0]        num_y;
    logic [DW:0]          dr_x;
    logic [DW:0]          dr_y;
  } amfco_pipe_t;

endpackage

/* design/amfco_front.sv */
module amfco_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    valid_i,
  input  amfco_pkg::amfco_in_t    item_i,
  output logic                    valid_o,
  output amfco_pkg::amfco_pipe_t  pipe_o
);
  import amfco_pkg::*;

  logic        a_valid_r, b_valid_r, c_valid_r;
  amfco_pipe_t a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;

  logic signed [CW:0]   sx_e, sy_e, ex_e, ey_e, ox_e, oy_e;
  logic signed [CW:0]   dx, dy, hsx, hsy;
  logic signed [UW-1:0] ux, uy;
  logic [2*CW-1:0]      p_ox, p_oy;
  logic [2*CW+1:0]      p_dx, p_dy;
  logic [RN-1:0]        rr, r4, cc;

  // stage a: differences, centre, chord midpoint, magnitudes
  always_comb begin
    sx_e = {item_i.start_x[CW-1], item_i.start_x};
    sy_e = {item_i.start_y[CW-1], item_i.start_y};
    ex_e = {item_i.end_x[CW-1], item_i.end_x};
    ey_e = {item_i.end_y[CW-1], item_i.end_y};
    ox_e = {item_i.center_off_x[CW-1], item_i.center_off_x};
    oy_e = {item_i.center_off_y[CW-1], item_i.center_off_y};
    dx   = ex_e - sx_e;
    dy   = ey_e - sy_e;
    hsx  = sx_e + ex_e;
    hsy  = sy_e + ey_e;
    ux   = {ox_e, 1'b0} - {dx[CW], dx};
    uy   = {oy_e, 1'b0} - {dy[CW], dy};
    a_nxt        = '0;
    a_nxt.cx     = sx_e + ox_e;
    a_nxt.cy     = sy_e + oy_e;
    a_nxt.hx     = hsx[CW:1];
    a_nxt.hy     = hsy[CW:1];
    a_nxt.z      = item_i.end_z;
    a_nxt.ux_neg = ux[UW-1];
    a_nxt.uy_neg = uy[UW-1];
    a_nxt.ux_m   = ux[UW-1] ? UW'(-ux) : UW'(ux);
    a_nxt.uy_m   = uy[UW-1] ? UW'(-uy) : UW'(uy);
    a_nxt.ox_m   = item_i.center_off_x[CW-1] ? CW'(-item_i.center_off_x)
                                             : CW'(item_i.center_off_x);
    a_nxt.oy_m   = item_i.center_off_y[CW-1] ? CW'(-item_i.center_off_y)
                                             : CW'(item_i.center_off_y);
    a_nxt.dx_m   = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
    a_nxt.dy_m   = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
  end

  // stage b: four squares
  assign p_ox = a_r.ox_m * a_r.ox_m;
  assign p_oy = a_r.oy_m * a_r.oy_m;
  assign p_dx = a_r.dx_m * a_r.dx_m;
  assign p_dy = a_r.dy_m * a_r.dy_m;

  always_comb begin
    b_nxt       = a_r;
    b_nxt.sq_ox = SQW'(p_ox);
    b_nxt.sq_oy = SQW'(p_oy);
    b_nxt.sq_dx = SQW'(p_dx);
    b_nxt.sq_dy = SQW'(p_dy);
  end

  // stage c: 4r^2 against chord^2, radicands
  assign rr = RN'(b_r.sq_ox) + RN'(b_r.sq_oy);
  assign r4 = rr << 2;
  assign cc = RN'(b_r.sq_dx) + RN'(b_r.sq_dy);

  always_comb begin
    c_nxt        = b_r;
    c_nxt.lt     = r4 < cc;
    c_nxt.eq     = r4 == cc;
    c_nxt.rem_r  = rr;
    c_nxt.rem_h  = (r4 < cc) ? '0 : r4 - cc;
    c_nxt.root_r = '0;
    c_nxt.root_h = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= valid_i;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
    end
  end

  assign valid_o = c_valid_r;
  assign pipe_o  = c_r;

endmodule

/* design/amfco_sqrt.sv */
module amfco_sqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    valid_i,
  input  amfco_pkg::amfco_pipe_t  pipe_i,
  output logic                    valid_o,
  output amfco_pkg::amfco_pipe_t  pipe_o
);
  import amfco_pkg::*;

  amfco_pipe_t link [0:RK];
  logic        vlink [0:RK];

  assign link[0]  = pipe_i;
  assign vlink[0] = valid_i;

  // one root bit per stage, both roots side by side, msb first
  for (genvar i = 0; i < RK; i++) begin : g_step
    localparam int B = RK - 1 - i;
    amfco_pipe_t   stage_r, stage_nxt;
    logic          valid_r;
    logic [RN-1:0] t_r, t_h;

    assign t_r = (RN'(link[i].root_r) << (B + 1)) | (RN'(1) << (2 * B));
    assign t_h = (RN'(link[i].root_h) << (B + 1)) | (RN'(1) << (2 * B));

    always_comb begin
      stage_nxt = link[i];
      if (link[i].rem_r >= t_r) begin
        stage_nxt.rem_r     = link[i].rem_r - t_r;
        stage_nxt.root_r[B] = 1'b1;
      end
      if (link[i].rem_h >= t_h) begin
        stage_nxt.rem_h     = link[i].rem_h - t_h;
        stage_nxt.root_h[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r <= 1'b0;
      end else if (en) begin
        valid_r <= vlink[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage_r <= stage_nxt;
      end
    end

    assign link[i+1]  = stage_r;
    assign vlink[i+1] = valid_r;
  end

  assign pipe_o  = link[RK];
  assign valid_o = vlink[RK];

endmodule

/* design/amfco_div.sv */
module amfco_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    valid_i,
  input  amfco_pkg::amfco_pipe_t  pipe_i,
  output logic                    valid_o,
  output amfco_pkg::amfco_pipe_t  pipe_o
);
  import amfco_pkg::*;

  function automatic logic [DW+NB:0] div_step(input logic [DW:0]   dr,
                                              input logic [NB-1:0] num,
                                              input logic [DW-1:0] d);
    logic [DW:0]   sh;
    logic [NB-1:0] n;
    sh = {dr[DW-1:0], num[NB-1]};
    n  = {num[NB-2:0], 1'b0};
    if (sh >= {1'b0, d}) begin
      sh   = sh - {1'b0, d};
      n[0] = 1'b1;
    end
    return {sh, n};
  endfunction

  amfco_pipe_t   m_r, m_nxt;
  logic          m_valid_r;
  logic [CW-1:0] root_lo;
  logic [NB-1:0] px, py;

  // r * |u| per axis, r is below 2^24
  assign root_lo = pipe_i.root_r[CW-1:0];
  assign px      = root_lo * pipe_i.ux_m;
  assign py      = root_lo * pipe_i.uy_m;

  always_comb begin
    m_nxt       = pipe_i;
    m_nxt.num_x = px;
    m_nxt.num_y = py;
    m_nxt.dr_x  = '0;
    m_nxt.dr_y  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_nxt;
    end
  end

  amfco_pipe_t link [0:NB];
  logic        vlink [0:NB];

  assign link[0]  = m_r;
  assign vlink[0] = m_valid_r;

  // restoring division, one quotient bit per stage for each axis
  for (genvar i = 0; i < NB; i++) begin : g_step
    amfco_pipe_t stage_r, stage_nxt;
    logic        valid_r;

    always_comb begin
      stage_nxt = link[i];
      {stage_nxt.dr_x, stage_nxt.num_x} = div_step(link[i].dr_x, link[i].num_x,
                                                   link[i].root_h);
      {stage_nxt.dr_y, stage_nxt.num_y} = div_step(link[i].dr_y, link[i].num_y,
                                                   link[i].root_h);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r <= 1'b0;
      end else if (en) begin
        valid_r <= vlink[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage_r <= stage_nxt;
      end
    end

    assign link[i+1]  = stage_r;
    assign vlink[i+1] = valid_r;
  end

  assign pipe_o  = link[NB];
  assign valid_o = vlink[NB];

endmodule

/* design/amfco_fin.sv */
module amfco_fin (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    valid_i,
  input  amfco_pkg::amfco_pipe_t  pipe_i,
  output logic                    out_valid,
  output amfco_pkg::amfco_out_t   out_item
);
  import amfco_pkg::*;

  localparam logic signed [MW-1:0] MAX_W = MW'(MID_MAX);
  localparam logic signed [MW-1:0] MIN_W = MW'(MID_MIN);

  // {saturated, clamped value}
  function automatic logic [CW:0] clamp_f(input logic signed [MW-1:0] v);
    logic [CW:0] res;
    if (v > MAX_W) begin
      res = {1'b1, MID_MAX};
    end else if (v < MIN_W) begin
      res = {1'b1, MID_MIN};
    end else begin
      res = {1'b0, v[CW-1:0]};
    end
    return res;
  endfunction

  logic                 rnd_x, rnd_y;
  logic [NB:0]          q_x, q_y;
  logic signed [MW-1:0] cxw, cyw, qxw, qyw, vx, vy;
  logic [CW:0]          kx, ky;
  logic                 out_valid_r;
  amfco_out_t           out_item_r, out_item_nxt;

  always_comb begin
    rnd_x = {pipe_i.dr_x, 1'b0} >= {2'b00, pipe_i.root_h};
    rnd_y = {pipe_i.dr_y, 1'b0} >= {2'b00, pipe_i.root_h};
    q_x   = {1'b0, pipe_i.num_x} + (NB+1)'(rnd_x);
    q_y   = {1'b0, pipe_i.num_y} + (NB+1)'(rnd_y);
    cxw   = {{(MW-CW-1){pipe_i.cx[CW]}}, pipe_i.cx};
    cyw   = {{(MW-CW-1){pipe_i.cy[CW]}}, pipe_i.cy};
    qxw   = {1'b0, q_x};
    qyw   = {1'b0, q_y};
    vx    = pipe_i.ux_neg ? cxw + qxw : cxw - qxw;
    vy    = pipe_i.uy_neg ? cyw + qyw : cyw - qyw;
    kx    = clamp_f(vx);
    ky    = clamp_f(vy);

    out_item_nxt.mid_z = pipe_i.z;
    if (pipe_i.lt || pipe_i.eq) begin
      out_item_nxt.mid_x  = pipe_i.hx;
      out_item_nxt.mid_y  = pipe_i.hy;
      out_item_nxt.status = pipe_i.lt ? ST_LONG : ST_HALF;
    end else begin
      out_item_nxt.mid_x  = kx[CW-1:0];
      out_item_nxt.mid_y  = ky[CW-1:0];
      out_item_nxt.status = (kx[CW] || ky[CW]) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* design/arc_midpoint_from_center_offset.sv */
// throughput: one item per cycle unless a stalled result holds the pipe; the depth is set by
//   one root bit per stage in the square-root pipe and one quotient bit per stage in the divider
// reset: rst_n synchronous, active low; clears every stage valid, payload kept
// back-pressure: a stalled result freezes the whole pipe in place
module arc_midpoint_from_center_offset (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  amfco_pkg::amfco_in_t   in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output amfco_pkg::amfco_out_t  out_item
);
  import amfco_pkg::*;

  // global advance: everything moves unless the result register is held
  logic en;

  logic        f_valid, s_valid, d_valid;
  amfco_pipe_t f_pipe, s_pipe, d_pipe;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // centre, chord midpoint, squares and the 4r^2 vs chord^2 test
  amfco_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_valid),
    .item_i  (in_item),
    .valid_o (f_valid),
    .pipe_o  (f_pipe)
  );

  // floor roots of r^2 and of 4r^2 - chord^2
  amfco_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (f_valid),
    .pipe_i  (f_pipe),
    .valid_o (s_valid),
    .pipe_o  (s_pipe)
  );

  // r * |u| / h2 for both axes
  amfco_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (s_valid),
    .pipe_i  (s_pipe),
    .valid_o (d_valid),
    .pipe_o  (d_pipe)
  );

  // rounding, offset from the centre, clamping, status and result register
  amfco_fin u_fin (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_i   (d_valid),
    .pipe_i    (d_pipe),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* design/amfco_chk.sv */
`include "arc_midpoint_from_center_offset_defines.svh"

module amfco_chk (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input amfco_pkg::amfco_out_t  out_item
);
  import amfco_pkg::*;

  `AMFCO_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result item changed")
  `AMFCO_ASSERT_IMP(a_in_stall_src, in_stall, out_valid && out_stall, "input stalled without result back-pressure")
  `AMFCO_ASSERT_IMP(a_sat_clamped, out_valid && out_item.status == ST_SAT, out_item.mid_x == MID_MAX || out_item.mid_x == MID_MIN || out_item.mid_y == MID_MAX || out_item.mid_y == MID_MIN, "saturated status without a clamped coordinate")

endmodule

bind arc_midpoint_from_center_offset amfco_chk u_amfco_chk (.*);

/* bench/tb_arc_midpoint_from_center_offset.sv */
`timescale 1ns / 100ps

module tb_arc_midpoint_from_center_offset;
  import amfco_pkg::*;

  localparam int PIPE_DEPTH = 81;        // pipeline depth of the design
  localparam longint Q_CAP = 64'd1 << 40;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  amfco_in_t  in_item;
  logic       out_valid;
  logic       out_stall;
  amfco_out_t out_item;

  amfco_out_t mid_expected[$];   // predicted midpoints, oldest first
  int         fail_count;
  int         burst_left;        // items left in the current sender burst
  int         hold_req;          // long receiver hold asked for by a test
  int         stall_mode;        // receiver pattern: 0 never, 1 light random, 2 heavy random

  arc_midpoint_from_center_offset i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [127:0] abs_wide(longint v);
    logic [127:0] m;
    m = (v < 0) ? 128'(-v) : 128'(v);
    return m;
  endfunction

  // floor square root, radicand below 2^68
  function automatic logic [127:0] floor_root(logic [127:0] n);
    logic [127:0] res;
    logic [127:0] cand;
    res = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = res | (128'd1 << b);
      if (cand * cand <= n) res = cand;
    end
    return res;
  endfunction

  // one axis of the minor-arc midpoint: c - sign(u) * round(r*|u| / h2)
  function automatic longint arc_axis(longint c, longint u, logic [127:0] r,
                                      logic [127:0] h2);
    logic [127:0] n;
    logic [127:0] q;
    logic [127:0] rem;
    n   = r * abs_wide(u);
    q   = n / h2;
    rem = n % h2;
    if (rem >= h2 - rem) q = q + 1;     // halves away from zero
    if (q > 128'(Q_CAP)) q = 128'(Q_CAP);
    return (u < 0) ? c + longint'(q) : c - longint'(q);
  endfunction

  function automatic longint clamp_coord(longint v, ref logic sat);
    if (v > longint'(MID_MAX)) begin
      sat = 1'b1;
      return longint'(MID_MAX);
    end
    if (v < longint'(MID_MIN)) begin
      sat = 1'b1;
      return longint'(MID_MIN);
    end
    return v;
  endfunction

  function automatic amfco_out_t predict_midpoint(amfco_in_t a);
    longint       sx, sy, ex, ey, ox, oy, dx, dy, mx, my;
    logic [127:0] rsq, r4, chord_sq, r, h2;
    logic         sat;
    amfco_status_t st;
    amfco_out_t   res;
    sx = a.start_x;
    sy = a.start_y;
    ex = a.end_x;
    ey = a.end_y;
    ox = a.center_off_x;
    oy = a.center_off_y;
    dx = ex - sx;
    dy = ey - sy;
    sat = 1'b0;
    rsq = abs_wide(ox) * abs_wide(ox) + abs_wide(oy) * abs_wide(oy);
    r4  = rsq << 2;
    chord_sq = abs_wide(dx) * abs_wide(dx) + abs_wide(dy) * abs_wide(dy);
    if (r4 <= chord_sq) begin
      // half circle or chord longer than the diameter: chord midpoint
      st = (r4 < chord_sq) ? ST_LONG : ST_HALF;
      mx = (sx + ex) >>> 1;
      my = (sy + ey) >>> 1;
    end else begin
      r  = floor_root(rsq);
      h2 = floor_root(r4 - chord_sq);
      mx = clamp_coord(arc_axis(sx + ox, 2 * ox - dx, r, h2), sat);
      my = clamp_coord(arc_axis(sy + oy, 2 * oy - dy, r, h2), sat);
      st = sat ? ST_SAT : ST_OK;
    end
    res.mid_x  = mx[CW-1:0];
    res.mid_y  = my[CW-1:0];
    res.mid_z  = a.end_z;
    res.status = st;
    return res;
  endfunction

  // ---------------------------------------------------------------- sender

  // drives one item, holds it until accepted, then maybe leaves a gap
  task automatic send_arc(amfco_in_t a);
    in_valid <= 1'b1;
    in_item  <= a;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    mid_expected.push_back(predict_midpoint(a));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  function automatic amfco_in_t make_arc(longint sx, longint sy, longint ex,
                                         longint ey, longint ez, longint ox,
                                         longint oy);
    amfco_in_t a;
    a.start_x      = sx[CW-1:0];
    a.start_y      = sy[CW-1:0];
    a.end_x        = ex[CW-1:0];
    a.end_y        = ey[CW-1:0];
    a.end_z        = ez[CW-1:0];
    a.center_off_x = ox[CW-1:0];
    a.center_off_y = oy[CW-1:0];
    return a;
  endfunction

  // mostly plausible arcs of random size, some broken chords and raw noise
  function automatic amfco_in_t random_arc();
    amfco_in_t    a;
    logic [191:0] noise;
    int           k;
    longint       sx, sy, ox, oy, lim;
    k = $urandom_range(0, 9);
    if (k < 2) begin
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      a = noise[$bits(amfco_in_t)-1:0];
      return a;
    end
    lim = 64'd1 << $urandom_range(1, 22);
    sx = $signed($urandom_range(0, 32'hFFFFFF)) - 64'sd8388608;
    sy = $signed($urandom_range(0, 32'hFFFFFF)) - 64'sd8388608;
    if (k < 4) begin
      sx = sx >>> $urandom_range(0, 20);
      sy = sy >>> $urandom_range(0, 20);
    end
    ox = longint'($urandom_range(0, 32'(2 * lim))) - lim;
    oy = longint'($urandom_range(0, 32'(2 * lim))) - lim;
    if (k < 9) begin
      // end point within a square around the centre, mostly a valid chord
      a = make_arc(sx, sy,
                   sx + ox + longint'($urandom_range(0, 32'(2 * lim))) - lim,
                   sy + oy + longint'($urandom_range(0, 32'(2 * lim))) - lim,
                   $urandom, ox, oy);
    end else begin
      // end mirrored through the centre: half circle
      a = make_arc(sx, sy, sx + 2 * ox, sy + 2 * oy, $urandom, ox, oy);
    end
    return a;
  endfunction

  // ---------------------------------------------------------------- receiver

  initial begin
    int hold_left;
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0 && hold_left == 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          default: out_stall <= ($urandom_range(0, 7) < 5);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
               act_v);
      fail_count++;
    end
  endtask

  initial begin
    amfco_out_t got;
    amfco_out_t want;
    logic       take;
    forever begin
      @(negedge clk);
      take = rst_n && out_valid && !out_stall;
      got  = out_item;
      @(posedge clk);
      if (take) begin
        if (mid_expected.size() == 0) begin
          $display("%0t: unexpected item, actual %h", $time, got);
          fail_count++;
        end else begin
          want = mid_expected.pop_front();
          check_field("mid_x", want.mid_x, got.mid_x);
          check_field("mid_y", want.mid_y, got.mid_y);
          check_field("mid_z", want.mid_z, got.mid_z);
          check_field("status", want.status, got.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    longint mx, mn;
    mx = longint'(MID_MAX);
    mn = longint'(MID_MIN);
    // degenerate: zero offset, start equals end
    send_arc(make_arc(0, 0, 0, 0, 0, 0, 0));
    // zero offset with a real chord: chord longer than the diameter
    send_arc(make_arc(10, -10, 30, 40, 5, 0, 0));
    // exact half circles along each axis, then a zero offset
    send_arc(make_arc(0, 0, 2000, 0, 1, 1000, 0));
    send_arc(make_arc(0, 0, 0, -2000, -1, 0, -1000));
    send_arc(make_arc(-5, 7, 4, -2, 3, 0, 0));
    // axis-aligned chords, both sides
    send_arc(make_arc(0, 0, 2000, 0, 2, 1000, 500));
    send_arc(make_arc(0, 0, 2000, 0, 2, 1000, -500));
    send_arc(make_arc(0, 0, 0, 2000, 2, 500, 1000));
    send_arc(make_arc(0, 0, 0, 2000, 2, -500, 1000));
    // quarter arc, start on end
    send_arc(make_arc(1000, 0, 0, 1000, 9, -1000, 0));
    send_arc(make_arc(123, 456, 123, 456, 7, 300, -400));
    // chord longer than the diameter
    send_arc(make_arc(0, 0, 5000, 5000, 4, 10, 10));
    // extremes of every field
    send_arc(make_arc(mx, mx, mx, mx, mx, mx, mx));
    send_arc(make_arc(mn, mn, mn, mn, mn, mn, mn));
    send_arc(make_arc(mn, mx, mx, mn, mn, mx, mn));
    send_arc(make_arc(mx, mn, mn, mx, mx, mn, mx));
    send_arc(make_arc(mx, mx, mx, mx - 1, 0, mx, mx));
    send_arc(make_arc(mn, mn, mn + 1, mn, 0, mn, mn));
    // large radius: a near half circle, then tiny chords at the extremes
    send_arc(make_arc(0, 0, 2 * 4000000 - 2, 0, 0, 4000000, 1));
    send_arc(make_arc(mx, 0, mx, 1, 0, mx, 0));
    send_arc(make_arc(mn, 0, mn, -1, 0, mn, 0));
    // unit sizes
    send_arc(make_arc(0, 0, 1, 0, -1, 1, 0));
    send_arc(make_arc(0, 0, 1, 1, 0, 1, 1));
    send_arc(make_arc(-1, -1, -1, -1, -1, -1, -1));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_arc(random_arc());
  endtask

  // receiver holds off long enough for the pipe to fill and stall the input
  task automatic test_backpressure();
    hold_req = 300;
    for (int i = 0; i < 150; i++) send_arc(random_arc());
  endtask

  task automatic drain();
    int spin;
    in_valid <= 1'b0;
    spin = 0;
    while (mid_expected.size() != 0 && spin < 200000) begin
      @(posedge clk);
      spin++;
    end
    repeat (PIPE_DEPTH + 20) @(posedge clk);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    fail_count = 0;
    burst_left = 0;
    hold_req   = 0;
    stall_mode = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(450);
    test_backpressure();
    test_random(430);
    drain();
    if (fail_count == 0 && mid_expected.size() == 0) begin
      $display("tb_arc_midpoint_from_center_offset: PASS");
    end else begin
      $display("tb_arc_midpoint_from_center_offset: FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5000000;
    $display("tb_arc_midpoint_from_center_offset: FAIL");
    $finish;
  end

endmodule
